// ===== hw/rtl/mhm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modulo hash multiset package
// Operation and status codes, controller states and the width of one step of
// the modulo unit, shared by the modulo unit and the top-level module.
// ----------------------------------------------------------------------------
package mhm_pkg;

   // Key bits folded into the running residue in one clock cycle.
   localparam int MOD_STEPS = 8;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_SEARCH   = 2'd1,
      OP_DELETE   = 2'd2,
      OP_LOOKUP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_ABSENT = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_CMP,
      ST_WRITE
   } state_type;

endpackage

// ===== hw/rtl/mhm_mod_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modulo hash multiset: bucket index unit
// Reduces a key modulo the bucket count, most significant bit first, folding
// MOD_STEPS key bits into the residue per cycle with compare and subtract.
// ----------------------------------------------------------------------------
module mhm_mod_unit
   import mhm_pkg::*;
#(
   parameter int KEY_BITS    = 31,
   parameter int NUM_BUCKETS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [KEY_BITS-1:0]            key,
   output logic                           busy,
   output logic [$clog2(NUM_BUCKETS)-1:0] residue
);

   localparam int PAD_BITS = ((KEY_BITS + MOD_STEPS - 1) / MOD_STEPS) * MOD_STEPS;
   localparam int CYCLES   = PAD_BITS / MOD_STEPS;
   localparam int CW       = $clog2(CYCLES + 1);
   localparam int RW       = $clog2(NUM_BUCKETS);

   logic [PAD_BITS-1:0] shift_ff, shift_in;
   logic [RW-1:0]       rem_ff, rem_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [RW-1:0]       folded;

   // The residue stays below the bucket count, so one subtraction per bit
   // keeps it in range.
   always_comb begin
      logic [RW:0]   t;
      logic [RW-1:0] r;
      r = rem_ff;
      for (int j = 0; j < MOD_STEPS; j++) begin
         t = {r, shift_ff[PAD_BITS-1-j]};
         if (t >= (RW+1)'(NUM_BUCKETS)) begin
            t = t - (RW+1)'(NUM_BUCKETS);
         end
         r = t[RW-1:0];
      end
      folded = r;
   end

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      if (start) begin
         shift_in = PAD_BITS'(key);
         rem_in   = '0;
         count_in = CW'(CYCLES);
      end else if (count_ff != '0) begin
         shift_in = shift_ff << MOD_STEPS;
         rem_in   = folded;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign busy    = (count_ff != '0);
   assign residue = rem_ff;

endmodule

// ===== hw/rtl/mhm_bucket_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modulo hash multiset: bucket row memory
// One row per bucket holding the fill count and every way's key. Synchronous
// read with registered data; a valid bit per row makes unwritten rows read
// as empty after reset.
// ----------------------------------------------------------------------------
module mhm_bucket_mem #(
   parameter int NUM_BUCKETS = 10,
   parameter int ROW_BITS    = 252
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [$clog2(NUM_BUCKETS)-1:0] rd_addr,
   output logic [ROW_BITS-1:0]            rd_row,
   output logic                           rd_valid,
   input  logic                           wr_en,
   input  logic [$clog2(NUM_BUCKETS)-1:0] wr_addr,
   input  logic [ROW_BITS-1:0]            wr_row
);

   logic [ROW_BITS-1:0] row_mem [NUM_BUCKETS];
   logic [ROW_BITS-1:0] rd_row_ff;
   logic                valid_ff [NUM_BUCKETS];
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= row_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            valid_ff[b] <= 1'b0;
         end
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_row   = rd_row_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// ===== hw/rtl/modulo_hash_multiset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modulo hash multiset
// Hashed multiset of keys with insert, search and delete-one-copy, bucketed by
// key modulo the bucket count, each bucket holding a fixed number of ways.
// ----------------------------------------------------------------------------
// One operation is handled at a time, from its transfer on the request side
// to its result being offered. The modulo unit folds eight key bits into the
// bucket index per cycle; then the bucket row is read from the row memory and
// compared against all ways. Once any earlier result has been collected, the
// result is loaded and, for a successful insert or delete, the row is written
// back. A new request is taken as soon as the result sits in the output
// register, even if it has not yet been collected. All buckets read as empty
// straight after reset, with no clearing pass. An insert into a full bucket is refused.
// ----------------------------------------------------------------------------
module modulo_hash_multiset
   import mhm_pkg::*;
#(
   parameter int NUM_BUCKETS = 10,
   parameter int BUCKET_WAYS = 8,
   parameter int KEY_BITS    = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // operation [1:0], key [32:2], zero [39:33]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // present [0], status [2:1], zero [7:3]
);

   localparam int RW       = $clog2(NUM_BUCKETS);
   localparam int FW       = $clog2(BUCKET_WAYS + 1);
   localparam int WW       = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
   localparam int ROW_BITS = BUCKET_WAYS * KEY_BITS + FW;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                present_ff, present_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [WW-1:0]       way_ff, way_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_present_ff, rsp_present_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic                req_accept;
   logic                mod_start;
   logic                mod_busy;
   logic [RW-1:0]       bucket;
   logic                rd_en;
   logic [ROW_BITS-1:0] rd_row;
   logic                rd_valid;
   logic                rsp_load;
   logic                wr_req;
   logic                wr_en;
   logic [ROW_BITS-1:0] wr_row;
   status_type          status;
   logic [FW-1:0]       row_fill;
   logic                hit;
   logic [WW-1:0]       hit_way;

   mhm_mod_unit #(
      .KEY_BITS    (KEY_BITS),
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .key     (key_in),
      .busy    (mod_busy),
      .residue (bucket)
   );

   // The residue holds until the next start, so it addresses both the read
   // and the write-back of the same row.
   mhm_bucket_mem #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .ROW_BITS    (ROW_BITS)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (bucket),
      .rd_row   (rd_row),
      .rd_valid (rd_valid),
      .wr_en    (wr_en),
      .wr_addr  (bucket),
      .wr_row   (wr_row)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (!mod_busy) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_MOD: begin
            rd_en = !mod_busy;
         end
         ST_CMP: begin
         end
         ST_WRITE: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   assign req_accept = req_tvalid && req_tready;
   assign mod_start  = req_accept;
   assign wr_en      = rsp_load && wr_req;

   // Lookup over the row just read; the lowest matching way wins.
   always_comb begin
      row_fill = rd_valid ? rd_row[ROW_BITS-1 -: FW] : '0;
      hit      = 1'b0;
      hit_way  = '0;
      for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
         if ((FW'(w) < row_fill) && (rd_row[w*KEY_BITS +: KEY_BITS] == key_ff)) begin
            hit     = 1'b1;
            hit_way = WW'(w);
         end
      end
   end

   // Row update. A delete moves the last occupied way into the freed slot.
   always_comb begin
      logic [WW-1:0]       last_way;
      logic [KEY_BITS-1:0] last_key;
      logic [FW-1:0]       new_fill;
      last_way = fill_ff[WW-1:0] - 1'b1;
      last_key = '0;
      for (int w = 0; w < BUCKET_WAYS; w++) begin
         if (WW'(w) == last_way) begin
            last_key = rd_row[w*KEY_BITS +: KEY_BITS];
         end
      end
      wr_row   = rd_row;
      new_fill = fill_ff;
      wr_req   = 1'b0;
      status   = STATUS_DONE;
      case (op_ff)
         OP_INSERT: begin
            if (fill_ff >= FW'(BUCKET_WAYS)) begin
               status = STATUS_FULL;
            end else begin
               for (int w = 0; w < BUCKET_WAYS; w++) begin
                  if (WW'(w) == fill_ff[WW-1:0]) begin
                     wr_row[w*KEY_BITS +: KEY_BITS] = key_ff;
                  end
               end
               new_fill = fill_ff + 1'b1;
               wr_req   = 1'b1;
            end
         end
         OP_DELETE: begin
            if (!present_ff) begin
               status = STATUS_ABSENT;
            end else begin
               for (int w = 0; w < BUCKET_WAYS; w++) begin
                  if (WW'(w) == way_ff) begin
                     wr_row[w*KEY_BITS +: KEY_BITS] = last_key;
                  end
               end
               new_fill = fill_ff - 1'b1;
               wr_req   = 1'b1;
            end
         end
         default: begin
            status = present_ff ? STATUS_DONE : STATUS_ABSENT;
         end
      endcase
      wr_row[ROW_BITS-1 -: FW] = new_fill;
   end

   // Datapath registers
   always_comb begin
      op_in          = op_ff;
      key_in         = key_ff;
      present_in     = present_ff;
      fill_in        = fill_ff;
      way_in         = way_ff;
      rsp_present_in = rsp_present_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (req_accept) begin
         op_in  = op_type'(req_tdata[1:0]);
         key_in = KEY_BITS'(req_tdata[32:2]);
      end
      if (state_ff == ST_CMP) begin
         present_in = hit;
         fill_in    = row_fill;
         way_in     = hit_way;
      end
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_present_in = present_ff;
         rsp_status_in  = status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      present_ff     <= present_in;
      fill_ff        <= fill_in;
      way_ff         <= way_in;
      rsp_present_ff <= rsp_present_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_status_ff, rsp_present_ff};

endmodule
